// ===== rtl/sqlkt_pkg.sv =====
// shared types, character codes, token kinds and helpers of the sql keyword tokenizer
package sqlkt_pkg;

   // offset counters
   localparam int POS_W = 16;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam int EXT_W = (POS_W > 16) ? POS_W : 16;

   // result queue
   localparam int RQ_DEPTH = 4;
   localparam int RQ_AW = $clog2(RQ_DEPTH);
   localparam int RQ_CW = RQ_AW + 1;

   // keyword buffer holds up to seven characters
   localparam int KW_CHARS = 7;
   localparam int KW_W = 8 * KW_CHARS;
   localparam int KW_NUM = 30;

   // token kinds
   localparam logic [5:0] KIND_EOF = 6'd0;
   localparam logic [5:0] KIND_ERROR = 6'd1;
   localparam logic [5:0] KIND_IDENT = 6'd2;
   localparam logic [5:0] KIND_NUMBER = 6'd3;
   localparam logic [5:0] KIND_STRING = 6'd4;
   localparam logic [5:0] KIND_EQ = 6'd5;
   localparam logic [5:0] KIND_COMMA = 6'd6;
   localparam logic [5:0] KIND_STAR = 6'd7;
   localparam logic [5:0] KIND_LPAREN = 6'd8;
   localparam logic [5:0] KIND_RPAREN = 6'd9;
   localparam logic [5:0] KIND_SEMI = 6'd10;
   localparam logic [5:0] KIND_KW_BASE = 6'd11;

   // characters
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_AT = 8'h40;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_CASE_BIT = 8'h20;

   // keywords, first character in the highest used byte
   localparam logic [KW_W-1:0] KW_TEXT [KW_NUM] = '{
      KW_W'("count"), KW_W'("sum"), KW_W'("avg"), KW_W'("max"), KW_W'("min"),
      KW_W'("order"), KW_W'("by"), KW_W'("limit"), KW_W'("asc"), KW_W'("desc"),
      KW_W'("index"), KW_W'("create"), KW_W'("table"), KW_W'("join"),
      KW_W'("inner"), KW_W'("on"), KW_W'("int"), KW_W'("varchar"),
      KW_W'("primary"), KW_W'("key"), KW_W'("explain"), KW_W'("select"),
      KW_W'("insert"), KW_W'("update"), KW_W'("delete"), KW_W'("set"),
      KW_W'("where"), KW_W'("from"), KW_W'("into"), KW_W'("values")
   };

   // scanner state
   typedef enum logic [3:0] {
      SCAN_IDLE   = 4'b0001,
      SCAN_IDENT  = 4'b0010,
      SCAN_NUMBER = 4'b0100,
      SCAN_STRING = 4'b1000
   } scan_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] byte_req;
   } item_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start_res;
      logic [15:0] length;
      logic [7:0]  error_byte;
      logic        last;
   } rsp_type;

   function automatic logic [15:0] clamp16(input logic [POS_W-1:0] v);
      logic [EXT_W-1:0] w;
      w = EXT_W'(v);
      if (w > EXT_W'(17'h0FFFF)) return 16'hFFFF;
      else return w[15:0];
   endfunction

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      if (v == POS_MAX) return v;
      else return v + POS_W'(1);
   endfunction

   function automatic rsp_type make_rsp(input logic [5:0] kind,
                                        input logic [POS_W-1:0] start,
                                        input logic [POS_W-1:0] len,
                                        input logic [7:0] err);
      rsp_type r;
      r.kind = kind;
      r.start_res = clamp16(start);
      r.length = clamp16(len);
      r.error_byte = err;
      r.last = 1'b0;
      return r;
   endfunction

   // keyword kind for a buffered word, or zero
   function automatic logic [5:0] kw_lookup(input logic [KW_W-1:0] buf_v);
      logic [5:0] k;
      k = '0;
      for (int i = 0; i < KW_NUM; i++) begin
         if (buf_v == KW_TEXT[i]) k = KIND_KW_BASE + 6'(i);
      end
      return k;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

endpackage

// ===== rtl/sql_keyword_tokenizer.sv =====
// top level of the streaming sql keyword tokenizer
//
// channel  dir  handshake                  payload
// req      in   req_tvalid / req_tready    tdata = byte_req[7:0], tuser = mode
// rsp      out  rsp_tvalid / rsp_tready    tdata = kind, start_res, length, error_byte;
//                                          tlast = last
//
// one byte item per clock: the item sits in an input register, the scanner
// decides its tokens combinationally and writes them into a four-entry result queue
// an item that closes a word and is itself a token yields two results, which drain
// one per cycle while rsp_tready is high; the scanner stalls only when the queue
// has fewer than two free slots; the input register keeps accepting while results
// wait, so a stalled rsp side throttles req only once three results are queued
// synchronous reset returns the scanner to idle at offset zero and empties the queue
module sql_keyword_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_req[7:0]
   input  logic        req_tuser,   // mode: 0 data byte, 1 end of statement
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // kind[5:0], start_res[21:6], length[37:22],
                                    // error_byte[45:38], zero[47:46]
   output logic        rsp_tlast
);
   import sqlkt_pkg::*;

   item_type   item_ff;
   logic       in_vld_ff, in_vld_in;
   logic       fire, room2, not_empty;
   rsp_type    res0, res1, head;
   logic [1:0] res_n;

   // scanner takes the held item when two result slots are free
   assign fire = in_vld_ff && room2;
   assign req_tready = !in_vld_ff || fire;
   assign in_vld_in = (req_tvalid && req_tready) || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= in_vld_in;
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.mode <= req_tuser;
         item_ff.byte_req <= req_tdata;
      end
   end

   sqlkt_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .item  (item_ff),
      .res0  (res0),
      .res1  (res1),
      .res_n (res_n)
   );

   sqlkt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_n      (fire ? res_n : 2'd0),
      .wr0       (res0),
      .wr1       (res1),
      .rd        (rsp_tready),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata = {2'b00, head.error_byte, head.length, head.start_res, head.kind};
   assign rsp_tlast = head.last;

endmodule

// ===== rtl/sqlkt_lexer.sv =====
// scanner state and token decision for one byte per cycle while step is high
module sqlkt_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  sqlkt_pkg::item_type item,
   output sqlkt_pkg::rsp_type  res0,
   output sqlkt_pkg::rsp_type  res1,
   output logic [1:0]        res_n
);
   import sqlkt_pkg::*;

   scan_type          scan_ff, scan_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  tok_ff, tok_in;
   logic [KW_W-1:0]   kwb_ff, kwb_in;
   logic [2:0]        kwc_ff, kwc_in;
   logic              ovl_ff, ovl_in;

   logic [7:0]        c, lc;
   logic [POS_W-1:0]  pos_inc, wlen;
   logic [5:0]        kw_kind, punct;
   logic              is_space, is_ident_char;
   rsp_type           pend_res, idle_res, b_res;
   logic              emit_a, emit_b;

   assign c = item.byte_req;
   assign lc = (c >= "A" && c <= "Z") ? (c | CH_CASE_BIT) : c;
   assign pos_inc = sat_inc(pos_ff);
   assign wlen = pos_ff - tok_ff;
   assign kw_kind = ovl_ff ? 6'd0 : kw_lookup(kwb_ff);
   assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   assign is_ident_char = is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_AT
                          || c == CH_DOT;

   always_comb begin
      case (c)
         CH_EQ:     punct = KIND_EQ;
         CH_COMMA:  punct = KIND_COMMA;
         CH_STAR:   punct = KIND_STAR;
         CH_LPAREN: punct = KIND_LPAREN;
         CH_RPAREN: punct = KIND_RPAREN;
         CH_SEMI:   punct = KIND_SEMI;
         default:   punct = 6'd0;
      endcase
   end

   // token that is pending in the current scan mode
   always_comb begin
      case (scan_ff)
         SCAN_IDENT: begin
            if (kw_kind != 6'd0) pend_res = make_rsp(kw_kind, tok_ff, '0, 8'd0);
            else pend_res = make_rsp(KIND_IDENT, tok_ff, wlen, 8'd0);
         end
         SCAN_NUMBER: pend_res = make_rsp(KIND_NUMBER, tok_ff, wlen, 8'd0);
         SCAN_STRING: pend_res = make_rsp(KIND_STRING, tok_ff, wlen, 8'd0);
         default:     pend_res = '0;
      endcase
   end

   // token of a byte seen between tokens
   always_comb begin
      if (punct != 6'd0) idle_res = make_rsp(punct, pos_ff, '0, 8'd0);
      else idle_res = make_rsp(KIND_ERROR, pos_ff, POS_W'(1), c);
   end

   always_comb begin
      scan_in = scan_ff;
      pos_in = pos_ff;
      tok_in = tok_ff;
      kwb_in = kwb_ff;
      kwc_in = kwc_ff;
      ovl_in = ovl_ff;
      emit_a = 1'b0;
      emit_b = 1'b0;
      b_res = idle_res;
      if (item.mode) begin
         emit_a = (scan_ff != SCAN_IDLE);
         emit_b = 1'b1;
         b_res = make_rsp(KIND_EOF, pos_ff, '0, 8'd0);
         scan_in = SCAN_IDLE;
         pos_in = '0;
         tok_in = '0;
         kwb_in = '0;
         kwc_in = '0;
         ovl_in = 1'b0;
      end else if (scan_ff == SCAN_STRING) begin
         pos_in = pos_inc;
         if (c == CH_QUOTE) begin
            emit_a = 1'b1;
            scan_in = SCAN_IDLE;
         end
      end else if (scan_ff == SCAN_IDENT && is_ident_char) begin
         pos_in = pos_inc;
         if (kwc_ff < 3'(KW_CHARS)) begin
            kwb_in = {kwb_ff[KW_W-9:0], lc};
            kwc_in = kwc_ff + 3'd1;
         end else begin
            ovl_in = 1'b1;
         end
      end else if (scan_ff == SCAN_NUMBER && is_digit(c)) begin
         pos_in = pos_inc;
      end else begin
         // ends any word, then the byte is taken as between tokens
         emit_a = (scan_ff != SCAN_IDLE);
         scan_in = SCAN_IDLE;
         pos_in = pos_inc;
         if (is_space) begin
            emit_b = 1'b0;
         end else if (punct != 6'd0) begin
            emit_b = 1'b1;
         end else if (c == CH_QUOTE) begin
            tok_in = pos_inc;
            scan_in = SCAN_STRING;
         end else if (is_alpha(c) || c == CH_UNDER) begin
            tok_in = pos_ff;
            kwb_in = KW_W'(lc);
            kwc_in = 3'd1;
            ovl_in = 1'b0;
            scan_in = SCAN_IDENT;
         end else if (is_digit(c)) begin
            tok_in = pos_ff;
            scan_in = SCAN_NUMBER;
         end else begin
            emit_b = 1'b1;
         end
      end
   end

   // order the results and mark the final one
   always_comb begin
      res0 = '0;
      res1 = '0;
      res_n = 2'd0;
      if (emit_a && emit_b) begin
         res0 = pend_res;
         res1 = b_res;
         res1.last = 1'b1;
         res_n = 2'd2;
      end else if (emit_a) begin
         res0 = pend_res;
         res0.last = 1'b1;
         res_n = 2'd1;
      end else if (emit_b) begin
         res0 = b_res;
         res0.last = 1'b1;
         res_n = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SCAN_IDLE;
         pos_ff <= '0;
         tok_ff <= '0;
         kwb_ff <= '0;
         kwc_ff <= '0;
         ovl_ff <= 1'b0;
      end else if (step) begin
         scan_ff <= scan_in;
         pos_ff <= pos_in;
         tok_ff <= tok_in;
         kwb_ff <= kwb_in;
         kwc_ff <= kwc_in;
         ovl_ff <= ovl_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && item.mode) |=> (scan_ff == SCAN_IDLE && pos_ff == '0))
      else $error("end of statement did not clear scanner");

   a_tok_order: assert property (@(posedge clock) disable iff (reset)
      (scan_ff != SCAN_IDLE) |-> (tok_ff <= pos_ff))
      else $error("token start beyond position");

   a_two_results: assert property (@(posedge clock) disable iff (reset)
      (step && res_n == 2'd2) |-> (!res0.last && res1.last && res0.kind != KIND_EOF))
      else $error("bad pair of results");

endmodule

// ===== rtl/sqlkt_rsp_fifo.sv =====
// small result queue taking up to two items per cycle
module sqlkt_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        wr_n,
   input  sqlkt_pkg::rsp_type  wr0,
   input  sqlkt_pkg::rsp_type  wr1,
   input  logic              rd,
   output sqlkt_pkg::rsp_type  head,
   output logic              not_empty,
   output logic              room2
);
   import sqlkt_pkg::*;

   rsp_type            entry_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CW-1:0]   cnt_ff, cnt_in;
   logic               rd_en;

   assign not_empty = (cnt_ff != '0);
   assign room2 = (cnt_ff <= RQ_CW'(RQ_DEPTH - 2));
   assign head = entry_ff[rd_ptr_ff];
   assign rd_en = rd && not_empty;

   assign wr_ptr_in = wr_ptr_ff + RQ_AW'(wr_n);
   assign rd_ptr_in = rd_ptr_ff + RQ_AW'(rd_en);
   assign cnt_in = cnt_ff + RQ_CW'(wr_n) - RQ_CW'(rd_en);

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) entry_ff[wr_ptr_ff] <= wr0;
      if (wr_n == 2'd2) entry_ff[wr_ptr_ff + RQ_AW'(1)] <= wr1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr_n != 2'd0) |-> (RQ_CW'(wr_n) <= RQ_CW'(RQ_DEPTH) - cnt_ff))
      else $error("result queue overflow");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RQ_CW'(RQ_DEPTH))
      else $error("result count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[RQ_AW-1:0] == RQ_AW'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
